// ----- hw/rtl/amx_pkg.sv -----
// Shared opcodes, status codes and controller/datapath interface types.
`default_nettype none
package amx_pkg;

	localparam int VERTEX_W = 4;
	localparam int OPCODE_W = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int FIELD_LIMIT = 16;

	localparam logic [OPCODE_W-1:0] OP_ADD      = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_REMOVE   = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_QUERY    = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_LIST_OUT = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_LIST_IN  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd3;

	localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 5'd16;

	typedef struct packed {
		logic capture;
		logic exec;
		logic scan_start;
		logic scan_step;
		logic scan_finish;
	} amx_cmd_t;

	typedef struct packed {
		logic op_valid;
		logic is_list;
		logic in_range;
		logic scan_done;
		logic hit;
		logic pend_valid;
		logic out_free;
	} amx_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/adjacency_matrix_engine.sv -----
// Top level of the directed-graph adjacency-matrix engine.
// Requests enter on the s_ stream, results leave on the m_ stream, one item per
// request except for neighbour lists, which give one item per neighbour in
// ascending order (tlast on the final one) or a single item with neighbor_valid
// low when the list is empty. Edge add, remove and query are captured, then
// executed into the result register; a list scans a row or column of the
// matrix one vertex per cycle, up to the effective vertex count.
// Undefined opcodes are dropped without a result. Output back-pressure stalls
// the scan. The matrix is cleared by reset; vertex_count may be written only
// while no request is in flight.
`default_nettype none
module adjacency_matrix_engine
	import amx_pkg::*;
#(
	parameter int MAX_VERTICES = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [15:0]         s_tdata,   // opcode[2:0], src_vertex[6:3], dst_vertex[10:7]
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata,   // status[1:0], edge_present[2], neighbor[6:3],
	                                            // neighbor_valid[7]
	output logic                     m_tlast,
	input  wire logic                cfg_we,
	input  wire logic [COUNT_W-1:0]  cfg_wdata  // vertex_count
);

	amx_cmd_t  cmd;
	amx_stat_t stat;

	amx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	amx_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/amx_ctrl.sv -----
// Request sequencer: decode, single-result execution and list scan control.
`default_nettype none
module amx_ctrl
	import amx_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  amx_stat_t      stat,
	output amx_cmd_t       cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECODE = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!stat.op_valid) begin
					state_d = S_IDLE;
				end else if (stat.is_list && stat.in_range) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SCAN: begin
				if (stat.scan_done) begin
					state_d = S_FINISH;
				end else if (!(stat.hit && stat.pend_valid) || stat.out_free) begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.scan_finish = 1'b1;
					state_d         = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/amx_datapath.sv -----
// Edge matrix, request registers, scan counter and result register.
`default_nettype none
module amx_datapath
	import amx_pkg::*;
#(
	parameter int MAX_VERTICES = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [15:0]         s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata,
	output logic                     m_tlast,
	input  wire logic                cfg_we,
	input  wire logic [COUNT_W-1:0]  cfg_wdata,
	input  amx_cmd_t                 cmd,
	output amx_stat_t                stat
);

	localparam int NV = (MAX_VERTICES < FIELD_LIMIT) ? MAX_VERTICES : FIELD_LIMIT;
	localparam int IW = $clog2(NV);
	localparam int CW = $clog2(NV + 1);

	logic [NV-1:0]         mat_q [NV];
	logic [COUNT_W-1:0]    vc_q;
	logic [OPCODE_W-1:0]   op_q;
	logic [VERTEX_W-1:0]   src_q;
	logic [VERTEX_W-1:0]   dst_q;
	logic [CW-1:0]         v_q;
	logic                  pend_valid_q;
	logic [IW-1:0]         pend_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic                  out_present_q;
	logic [VERTEX_W-1:0]   out_nb_q;
	logic                  out_nbv_q;
	logic                  out_last_q;

	logic [CW-1:0]         n_eff;
	logic [IW-1:0]         s_idx;
	logic [IW-1:0]         d_idx;
	logic [IW-1:0]         v_idx;
	logic [IW-1:0]         row_addr;
	logic [NV-1:0]         row_rd;
	logic                  edge_bit;
	logic                  hit;
	logic                  out_free;
	logic                  emit;

	// effective count saturates to the matrix size
	assign n_eff = (vc_q > COUNT_W'(NV)) ? CW'(NV) : vc_q[CW-1:0];

	assign s_idx    = src_q[IW-1:0];
	assign d_idx    = dst_q[IW-1:0];
	assign v_idx    = v_q[IW-1:0];
	assign row_addr = (op_q == OP_LIST_IN) ? v_idx : s_idx;
	assign row_rd   = mat_q[row_addr];
	assign edge_bit = row_rd[d_idx];
	assign hit      = (op_q == OP_LIST_OUT) ? row_rd[v_idx] : row_rd[s_idx];
	assign out_free = !out_valid_q || m_tready;
	assign emit     = cmd.scan_step && hit && pend_valid_q;

	assign stat.op_valid   = (op_q <= OP_LIST_IN);
	assign stat.is_list    = (op_q == OP_LIST_OUT) || (op_q == OP_LIST_IN);
	assign stat.in_range   = ({1'b0, src_q} < COUNT_W'(n_eff)) &&
	                         (stat.is_list || ({1'b0, dst_q} < COUNT_W'(n_eff)));
	assign stat.scan_done  = (v_q == n_eff);
	assign stat.hit        = hit;
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free   = out_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_nbv_q, out_nb_q, out_present_q, out_status_q};
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VERTEX_COUNT_RST;
		end else if (cfg_we) begin
			vc_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= s_tdata[OPCODE_W-1:0];
			src_q <= s_tdata[OPCODE_W +: VERTEX_W];
			dst_q <= s_tdata[OPCODE_W+VERTEX_W +: VERTEX_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NV; i++) begin
				mat_q[i] <= '0;
			end
		end else if (cmd.exec && stat.in_range) begin
			if (op_q == OP_ADD && !edge_bit) begin
				mat_q[s_idx][d_idx] <= 1'b1;
			end else if (op_q == OP_REMOVE && edge_bit) begin
				mat_q[s_idx][d_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q          <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.scan_start) begin
			v_q          <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.scan_step) begin
			v_q <= v_q + CW'(1);
			if (hit) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && hit) begin
			pend_q <= v_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec || emit || cmd.scan_finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_present_q <= stat.in_range && (op_q == OP_QUERY) && edge_bit;
			out_nb_q      <= '0;
			out_nbv_q     <= 1'b0;
			out_last_q    <= 1'b1;
			priority if (!stat.in_range) begin
				out_status_q <= ST_RANGE;
			end else if (op_q == OP_ADD && edge_bit) begin
				out_status_q <= ST_PRESENT;
			end else if (op_q == OP_REMOVE && !edge_bit) begin
				out_status_q <= ST_ABSENT;
			end else begin
				out_status_q <= ST_OK;
			end
		end else if (emit || cmd.scan_finish) begin
			out_status_q  <= ST_OK;
			out_present_q <= 1'b0;
			out_nb_q      <= pend_valid_q ? VERTEX_W'(pend_q) : '0;
			out_nbv_q     <= pend_valid_q;
			out_last_q    <= cmd.scan_finish;
		end
	end

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the directed-graph adjacency-matrix engine.
module tb_top;
	import amx_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 32;
	localparam int HOLD_CYCLES  = 250;
	localparam int MAX_REPORTS  = 40;
	localparam logic [OPCODE_W-1:0] OP_UNDEF_FIRST = OP_LIST_IN + 3'd1;
	localparam logic [OPCODE_W-1:0] OP_CODE_MAX    = '1;
	localparam logic [VERTEX_W-1:0] V_TOP          = '1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                present;
		logic [VERTEX_W-1:0] nb;
		logic                nb_valid;
		logic                last;
	} graph_result_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [15:0]         s_tdata;   // opcode[2:0], src_vertex[6:3], dst_vertex[10:7]
	logic                m_tvalid;
	logic                m_tready;
	logic [7:0]          m_tdata;   // status[1:0], edge_present[2], neighbor[6:3],
	                                // neighbor_valid[7]
	logic                m_tlast;
	logic                cfg_we;
	logic [COUNT_W-1:0]  cfg_wdata;

	// predictor state
	logic [FIELD_LIMIT-1:0] edge_mat [FIELD_LIMIT];
	logic [COUNT_W-1:0]     vcount;
	graph_result_t          awaited_results [$];

	int errors;
	int cycles;
	int n_requests;
	int n_results;
	int n_neighbours;
	int n_cfg;
	int burst_left;
	int hold_seq;
	int hold_done;

	adjacency_matrix_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d results still awaited", $time, awaited_results.size());
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int eff_count();
		return (vcount > FIELD_LIMIT) ? FIELD_LIMIT : int'(vcount);
	endfunction

	function automatic logic [VERTEX_W-1:0] pick_vertex(input int n);
		if (n > 0 && $urandom_range(0, 9) < 8)
			return VERTEX_W'($urandom_range(0, n - 1));
		return VERTEX_W'($urandom_range(0, FIELD_LIMIT - 1));
	endfunction

	task automatic queue_result(input graph_result_t r);
		awaited_results.insert(awaited_results.size(), r);
	endtask

	task automatic predict_graph_op(input logic [OPCODE_W-1:0] op,
			input logic [VERTEX_W-1:0] s, input logic [VERTEX_W-1:0] d);
		graph_result_t r;
		int n;
		int hits;
		logic hit;
		n = eff_count();
		hits = 0;
		r = '0;
		r.last = 1'b1;
		if (op > OP_LIST_IN)
			return;
		n_requests++;
		if (op == OP_ADD || op == OP_REMOVE || op == OP_QUERY) begin
			if (s >= n || d >= n) begin
				r.status = ST_RANGE;
			end else begin
				case (op)
					OP_ADD: begin
						if (edge_mat[s][d]) begin
							r.status = ST_PRESENT;
						end else begin
							edge_mat[s][d] = 1'b1;
							r.status = ST_OK;
						end
					end
					OP_REMOVE: begin
						if (!edge_mat[s][d]) begin
							r.status = ST_ABSENT;
						end else begin
							edge_mat[s][d] = 1'b0;
							r.status = ST_OK;
						end
					end
					default: begin
						r.status = ST_OK;
						r.present = edge_mat[s][d];
					end
				endcase
			end
			queue_result(r);
		end else if (s >= n) begin
			r.status = ST_RANGE;
			queue_result(r);
		end else begin
			for (int v = 0; v < n; v++) begin
				hit = (op == OP_LIST_OUT) ? edge_mat[s][v] : edge_mat[v][s];
				if (hit) begin
					r = '0;
					r.status = ST_OK;
					r.nb = VERTEX_W'(v);
					r.nb_valid = 1'b1;
					queue_result(r);
					hits++;
				end
			end
			if (hits == 0) begin
				r = '0;
				r.status = ST_OK;
				r.last = 1'b1;
				queue_result(r);
			end else begin
				r = awaited_results.pop_back();
				r.last = 1'b1;
				queue_result(r);
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// requests are predicted before results are checked within one edge
	always @(posedge clk) begin : monitor
		graph_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_graph_op(s_tdata[2:0], s_tdata[6:3], s_tdata[10:7]);
			if (m_tvalid && m_tready) begin
				n_results++;
				if (awaited_results.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected result, expected none, actual data %h last %b",
							$time, m_tdata, m_tlast);
				end else begin
					want = awaited_results.pop_front();
					if (want.nb_valid)
						n_neighbours++;
					check_field("status", want.status, m_tdata[1:0]);
					check_field("edge_present", want.present, m_tdata[2]);
					check_field("neighbor", want.nb, m_tdata[6:3]);
					check_field("neighbor_valid", want.nb_valid, m_tdata[7]);
					check_field("last", want.last, m_tlast);
				end
			end
		end
	end

	// receiver: stall pattern in random stretches, plus a long hold on request
	initial begin : receiver
		int left;
		int mode;
		left = 0;
		mode = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = hold_seq;
			end
			if (left == 0) begin
				left = $urandom_range(8, 64);
				mode = $urandom_range(0, 2);
			end
			left--;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic send_item(input logic [OPCODE_W-1:0] op,
			input logic [VERTEX_W-1:0] s, input logic [VERTEX_W-1:0] d);
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, d, s, op};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// sender works in bursts with random gaps between them
	task automatic offer(input logic [OPCODE_W-1:0] op,
			input logic [VERTEX_W-1:0] s, input logic [VERTEX_W-1:0] d);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send_item(op, s, d);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(input logic [COUNT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		vcount = v;
		n_cfg++;
	endtask

	task automatic send_random(input bit dense);
		int r;
		int n;
		logic [OPCODE_W-1:0] op;
		logic [VERTEX_W-1:0] s;
		logic [VERTEX_W-1:0] d;
		n = eff_count();
		r = $urandom_range(0, 99);
		if (r < 40)
			op = OP_ADD;
		else if (r < 52)
			op = OP_REMOVE;
		else if (r < 66)
			op = OP_QUERY;
		else if (r < 80)
			op = OP_LIST_OUT;
		else if (r < 94)
			op = OP_LIST_IN;
		else
			op = OPCODE_W'($urandom_range(OP_UNDEF_FIRST, OP_CODE_MAX));
		s = pick_vertex(n);
		d = pick_vertex(n);
		if (dense)
			s = VERTEX_W'($urandom_range(0, 2));
		offer(op, s, d);
	endtask

	task automatic run_phase(input logic [COUNT_W-1:0] count, input int items,
			input bit dense);
		wait_idle();
		set_count(count);
		repeat (items) send_random(dense);
	endtask

	task automatic test_empty_matrix();
		offer(OP_QUERY, 4'd0, 4'd0);
		offer(OP_QUERY, V_TOP, V_TOP);
		offer(OP_LIST_OUT, V_TOP, 4'd0);
		offer(OP_LIST_IN, 4'd0, V_TOP);
	endtask

	task automatic test_edge_updates();
		offer(OP_ADD, 4'd0, V_TOP);
		offer(OP_ADD, 4'd0, V_TOP);
		offer(OP_QUERY, 4'd0, V_TOP);
		offer(OP_ADD, 4'd5, 4'd5);
		offer(OP_REMOVE, 4'd0, V_TOP);
		offer(OP_REMOVE, 4'd0, V_TOP);
		offer(OP_QUERY, 4'd0, V_TOP);
		for (int op = OP_UNDEF_FIRST; op <= OP_CODE_MAX; op++)
			offer(OPCODE_W'(op), V_TOP, V_TOP);
	endtask

	task automatic test_neighbour_lists();
		offer(OP_ADD, 4'd0, 4'd3);
		offer(OP_ADD, V_TOP, 4'd3);
		offer(OP_ADD, 4'd3, 4'd9);
		offer(OP_LIST_IN, 4'd3, 4'd0);
		offer(OP_LIST_OUT, 4'd3, V_TOP);
	endtask

	// lowered count hides edges, zero rejects all, above 16 saturates
	task automatic test_vertex_count();
		wait_idle();
		set_count(5'd4);
		offer(OP_QUERY, V_TOP, 4'd0);
		offer(OP_ADD, 4'd3, 4'd0);
		offer(OP_LIST_OUT, V_TOP, 4'd0);
		offer(OP_LIST_IN, 4'd3, 4'd0);
		wait_idle();
		set_count(5'd0);
		offer(OP_ADD, 4'd0, 4'd0);
		offer(OP_LIST_IN, 4'd0, 4'd0);
		wait_idle();
		set_count(5'd1);
		offer(OP_ADD, 4'd0, 4'd0);
		offer(OP_LIST_OUT, 4'd0, 4'd0);
		wait_idle();
		set_count(5'd31);
		offer(OP_LIST_IN, 4'd3, 4'd0);
		offer(OP_LIST_IN, 4'd0, 4'd0);
	endtask

	task automatic test_random_traffic();
		run_phase(5'd16, 100, 1'b1);
		run_phase(5'd5, 70, 1'b0);
		run_phase(5'd1, 40, 1'b0);
		run_phase(5'd31, 60, 1'b0);
		run_phase(5'd0, 25, 1'b0);
		run_phase(COUNT_W'($urandom_range(2, 15)), 60, 1'b0);
		run_phase(5'd16, 75, 1'b0);
	endtask

	// hold the output so the block fills and stalls its input
	task automatic test_output_stall();
		wait_idle();
		set_count(5'd16);
		hold_seq++;
		for (int i = 0; i < 24; i++)
			send_item((i % 2) ? OP_LIST_IN : OP_LIST_OUT,
				VERTEX_W'($urandom_range(0, 3)), VERTEX_W'($urandom_range(0, 15)));
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		n_requests = 0;
		n_results = 0;
		n_neighbours = 0;
		n_cfg = 0;
		burst_left = 0;
		hold_seq = 0;
		hold_done = 0;
		vcount = VERTEX_COUNT_RST;
		for (int i = 0; i < FIELD_LIMIT; i++)
			edge_mat[i] = '0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = VERTEX_COUNT_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_matrix();
		test_edge_updates();
		test_neighbour_lists();
		test_vertex_count();
		test_random_traffic();
		test_output_stall();
		wait_idle();

		$display("%0d requests, %0d results checked, %0d of them neighbours, %0d count writes",
			n_requests, n_results, n_neighbours, n_cfg);
		$display("vertex counts 0, 1, 4, 5, 16 and 31 exercised; output held for %0d cycles",
			HOLD_CYCLES);
		if (errors == 0 && awaited_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
